// File: rtl/bwm_pkg.sv
package bwm_pkg;

  // Field widths
  localparam int unsigned CV_W  = 10;  // centivolt values and raw ADC samples
  localparam int unsigned PCT_W = 7;   // charge percentage

  // Raw-to-centivolt scale: floor(raw * 660 / 1024)
  localparam int unsigned CV_SCALE  = 660;
  localparam int unsigned RAW_SHIFT = 10;
  localparam int unsigned PROD_W    = CV_W + RAW_SHIFT;

  localparam logic [CV_W-1:0]  MIN_RESET = '1;  // above any converted sample
  localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);

  // Divider sizing: dividend holds |mean - empty| * 100, divisor a span
  localparam int unsigned DVD_W     = 17;
  localparam int unsigned DSR_W     = CV_W;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_FIELD_W = 2 + CV_W + PCT_W;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SPREAD_LIMIT    = 2'd0,
    REG_EXT_POWER_LIMIT = 2'd1,
    REG_EMPTY_LEVEL     = 2'd2,
    REG_FULL_LEVEL      = 2'd3
  } reg_idx_e;

  localparam logic [CV_W-1:0] SPREAD_RESET    = CV_W'(20);
  localparam logic [CV_W-1:0] EXT_LIMIT_RESET = CV_W'(450);
  localparam logic [CV_W-1:0] EMPTY_RESET     = CV_W'(320);
  localparam logic [CV_W-1:0] FULL_RESET      = CV_W'(410);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_PREP,
    ST_PCT,
    ST_DONE
  } seq_state_e;

  // Window statistics after folding in the current sample
  typedef struct packed {
    logic            last;
    logic [CV_W-1:0] min_cv;
    logic [CV_W-1:0] max_cv;
  } win_stat_t;

  function automatic logic [CV_W-1:0] raw_to_cv(input logic [CV_W-1:0] raw);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(raw) * PROD_W'(CV_SCALE);
    return prod[PROD_W-1:RAW_SHIFT];
  endfunction

endpackage

// File: rtl/bwm_div.sv
module bwm_div import bwm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [DSR_W-1:0]     dsr_q, dsr_d;
  logic [DSR_W-1:0]     rem_q, rem_d;
  logic [DSR_W:0]       rem_sh;
  logic [DSR_W:0]       rem_sub;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], fits};
      rem_d = fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// File: rtl/bwm_stats.sv
module bwm_stats import bwm_pkg::*; #(
  parameter int unsigned SAMPLES = 10,
  parameter int unsigned SUM_W   = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [CV_W-1:0]  sample_i,
  output win_stat_t        stat_o,
  output logic [SUM_W-1:0] sum_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CV_W-1:0]  min_q, min_d;
  logic [CV_W-1:0]  max_q, max_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CV_W-1:0]  cv;
  logic [CNT_W-1:0] cnt_nx;
  logic [CV_W-1:0]  min_nx;
  logic [CV_W-1:0]  max_nx;
  logic [SUM_W-1:0] sum_nx;

  assign cv     = raw_to_cv(sample_i);
  assign cnt_nx = cnt_q + CNT_W'(1);
  assign min_nx = (cv < min_q) ? cv : min_q;
  assign max_nx = (cv > max_q) ? cv : max_q;
  assign sum_nx = sum_q + SUM_W'(cv);

  assign stat_o.last   = cnt_nx == CNT_W'(SAMPLES);
  assign stat_o.min_cv = min_nx;
  assign stat_o.max_cv = max_nx;
  assign sum_o         = sum_nx;

  // Fold the sample in, or clear the window on its last sample
  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    max_d = max_q;
    sum_d = sum_q;
    if (acc_i) begin
      if (stat_o.last) begin
        cnt_d = '0;
        min_d = MIN_RESET;
        max_d = '0;
        sum_d = '0;
      end else begin
        cnt_d = cnt_nx;
        min_d = min_nx;
        max_d = max_nx;
        sum_d = sum_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= MIN_RESET;
      max_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      min_q <= min_d;
      max_q <= max_d;
      sum_q <= sum_d;
    end
  end

endmodule

// File: rtl/battery_window_monitor_unit.sv
// Battery voltage window monitor. Each transfer on the input stream carries one
// raw battery ADC sample and one raw external-supply sample; both are scaled to
// centivolts as floor(raw*660/1024). Over a window of SAMPLES transfers the unit
// tracks min, max and sum of the battery value. The last transfer of a window
// produces one output transfer: battery_connected (max-min within the spread
// limit), on_battery (external supply at or below its limit), the truncated mean
// voltage and a 0..100 charge percentage mapped linearly between the empty and
// full levels (both zero when not connected). Other transfers produce nothing.
// Sequence: a sample that does not close the window is absorbed without a
// stall. A closing sample holds tready low through ST_MEAN, which forms the
// mean from the registered sum by reciprocal multiplication, ST_PREP, which
// prepares the percentage operands, ST_PCT, where a 17-step restoring divider
// forms the percentage (skipped when not connected or the levels are equal),
// and ST_DONE, which loads the result. A finished result waits in the output
// register without blocking new samples; only a second result that finds that
// register still full holds tready low until the sink takes the first one.
// Configuration writes go through cfg_we_i/cfg_idx_i/cfg_data_i and must only
// happen while the unit is idle.
module battery_window_monitor_unit import bwm_pkg::*; #(
  parameter int unsigned SAMPLES = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CV_W-1:0]        cfg_data_i,
  // Sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [9:0] battery_sample, [19:10] ext_supply_sample, [23:20] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] battery_connected, [1] on_battery, [11:2] voltage_cv,
  // [18:12] charge_percent, [23:19] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SUM_W = $clog2(SAMPLES * 659 + 1);

  // Mean by reciprocal multiplication: with this shift the rounding error of
  // the reciprocal stays below one step over the whole sum range, so
  // (sum * MEAN_RECIP) >> MEAN_SHIFT equals sum / SAMPLES exactly.
  localparam int unsigned MEAN_SHIFT = SUM_W + $clog2(SAMPLES);
  localparam int unsigned RECIP_W    = MEAN_SHIFT + 1;
  localparam int unsigned MPROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'((2 ** MEAN_SHIFT + SAMPLES - 1) / SAMPLES);

  // Configuration registers
  logic [CV_W-1:0] spread_q, ext_limit_q, empty_q, full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q    <= SPREAD_RESET;
      ext_limit_q <= EXT_LIMIT_RESET;
      empty_q     <= EMPTY_RESET;
      full_q      <= FULL_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SPREAD_LIMIT:    spread_q    <= cfg_data_i;
        REG_EXT_POWER_LIMIT: ext_limit_q <= cfg_data_i;
        REG_EMPTY_LEVEL:     empty_q     <= cfg_data_i;
        REG_FULL_LEVEL:      full_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window statistics
  logic             in_acc;
  win_stat_t        stat;
  logic [SUM_W-1:0] sum;
  logic [CV_W-1:0]  ext_cv;
  logic [CV_W-1:0]  spread;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign ext_cv = raw_to_cv(s_axis_tdata[2*CV_W-1:CV_W]);
  assign spread = stat.max_cv - stat.min_cv;

  bwm_stats #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .sample_i (s_axis_tdata[CV_W-1:0]),
    .stat_o   (stat),
    .sum_o    (sum)
  );

  // Sequencer
  seq_state_e state_q, state_d;
  logic       div_done;
  logic [DVD_W-1:0] quot;
  logic       conn_q, onb_q, neg_q;
  logic [SUM_W-1:0] sum_q;
  logic [MPROD_W-1:0] mean_prod;
  logic [CV_W-1:0]  mean_q;
  logic [PCT_W-1:0] pct_q, pct_d;
  logic       out_free;
  logic       win_end;
  logic       pct_div;
  logic       div_start;
  logic       out_load;

  // Percentage operands, taken from the registered mean
  logic            num_neg, den_neg;
  logic [CV_W-1:0] num_abs, den_abs;
  logic [DVD_W-1:0] num_scaled;
  logic [DVD_W-1:0] div_dvd;
  logic [DSR_W-1:0] div_dsr;

  assign mean_prod  = MPROD_W'(sum_q) * MPROD_W'(MEAN_RECIP);

  assign num_neg    = mean_q < empty_q;
  assign num_abs    = num_neg ? (empty_q - mean_q) : (mean_q - empty_q);
  assign den_neg    = full_q < empty_q;
  assign den_abs    = den_neg ? (empty_q - full_q) : (full_q - empty_q);
  assign num_scaled = DVD_W'(num_abs) * DVD_W'(PCT_FULL);
  assign pct_div    = conn_q && (den_abs != '0);
  assign div_dvd    = num_scaled;
  assign div_dsr    = den_abs;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign win_end  = in_acc && stat.last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (win_end)  state_d = ST_MEAN;
      ST_MEAN: state_d = ST_PREP;
      ST_PREP: state_d = pct_div ? ST_PCT : ST_DONE;
      ST_PCT:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_PREP: div_start = pct_div;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  bwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Percentage: zero when not connected, equal levels compare directly, otherwise clamp the quotient
  always_comb begin
    pct_d = pct_q;
    if (state_q == ST_PREP) begin
      if (!conn_q) begin
        pct_d = '0;
      end else if (den_abs == '0) begin
        pct_d = (mean_q >= full_q) ? PCT_FULL : '0;
      end
    end else if (state_q == ST_PCT && div_done) begin
      if (neg_q) begin
        pct_d = '0;
      end else if (quot > DVD_W'(PCT_FULL)) begin
        pct_d = PCT_FULL;
      end else begin
        pct_d = quot[PCT_W-1:0];
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (win_end && state_q == ST_IDLE) begin
      conn_q <= spread <= spread_q;
      onb_q  <= ext_cv <= ext_limit_q;
      sum_q  <= sum;
    end
    if (state_q == ST_MEAN) begin
      mean_q <= conn_q ? mean_prod[MEAN_SHIFT +: CV_W] : '0;
    end
    if (state_q == ST_PREP) begin
      neg_q <= num_neg ^ den_neg;
    end
    pct_q <= pct_d;
  end

  // Output register: hold the result until the sink takes it
  logic                   out_valid_q;
  logic [OUT_FIELD_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {pct_q, mean_q, onb_q, conn_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_data_q};

endmodule

// File: verif/bwm_result_checker.sv
module bwm_result_checker import bwm_pkg::*; #(
  parameter int unsigned SAMPLES = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CV_W-1:0]        cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     mismatch_count_o,
  output int                     pending_o
);

  // Field order matches the result tdata layout, highest bits first
  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [CV_W-1:0]  volt;
    logic             on_batt;
    logic             connected;
  } gauge_t;

  gauge_t expected_q[$];
  int     mismatches;
  int     results_seen;

  logic [CV_W-1:0] spread_lim, ext_lim, empty_lvl, full_lvl;
  int unsigned     win_cnt, win_min, win_max, win_sum;

  function automatic int unsigned adc_to_cv(input logic [CV_W-1:0] raw);
    return (int'(raw) * 660) >> 10;
  endfunction

  function automatic logic [PCT_W-1:0] charge_of(input int unsigned volt);
    int num, den, p;
    num = int'(volt) - int'(empty_lvl);
    den = int'(full_lvl) - int'(empty_lvl);
    // equal levels: a step at the level instead of a division
    if (den == 0) return (volt >= full_lvl) ? PCT_FULL : '0;
    p = (num * 100) / den;
    if (p < 0) p = 0;
    if (p > 100) p = 100;
    return p[PCT_W-1:0];
  endfunction

  function automatic void clear_window();
    win_cnt = 0;
    win_min = 1023;
    win_max = 0;
    win_sum = 0;
  endfunction

  function automatic void absorb_sample(input logic [CV_W-1:0] batt_raw,
                                        input logic [CV_W-1:0] ext_raw);
    int unsigned cv, mean;
    gauge_t      res;
    cv = adc_to_cv(batt_raw);
    if (cv > win_max) win_max = cv;
    if (cv < win_min) win_min = cv;
    win_sum = win_sum + cv;
    win_cnt = (win_cnt + 1) & 4'hF;
    if (win_cnt < SAMPLES) return;
    res.connected = (win_max - win_min) <= spread_lim;
    res.on_batt   = adc_to_cv(ext_raw) <= ext_lim;
    mean          = res.connected ? win_sum / SAMPLES : 0;
    res.volt      = mean[CV_W-1:0];
    res.pct       = res.connected ? charge_of(mean) : '0;
    expected_q.push_back(res);
    clear_window();
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gauge_t got, want;
    if (!rst_ni) begin
      spread_lim = SPREAD_RESET;
      ext_lim    = EXT_LIMIT_RESET;
      empty_lvl  = EMPTY_RESET;
      full_lvl   = FULL_RESET;
      clear_window();
      expected_q.delete();
      mismatches   = 0;
      results_seen = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = gauge_t'(m_tdata_i[OUT_FIELD_W-1:0]);
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d with none pending: conn=%0b batt=%0b volt=%0d pct=%0d",
                                  results_seen, got.connected, got.on_batt, got.volt, got.pct));
        end else begin
          want = expected_q.pop_front();
          if (got.connected !== want.connected || got.on_batt !== want.on_batt ||
              got.volt !== want.volt || got.pct !== want.pct)
            flag_mismatch($sformatf(
              "result %0d expected conn=%0b batt=%0b volt=%0d pct=%0d, got conn=%0b batt=%0b volt=%0d pct=%0d",
              results_seen, want.connected, want.on_batt, want.volt, want.pct,
              got.connected, got.on_batt, got.volt, got.pct));
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SPREAD_LIMIT:    spread_lim = cfg_data_i;
          REG_EXT_POWER_LIMIT: ext_lim    = cfg_data_i;
          REG_EMPTY_LEVEL:     empty_lvl  = cfg_data_i;
          REG_FULL_LEVEL:      full_lvl   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        absorb_sample(s_tdata_i[CV_W-1:0], s_tdata_i[2*CV_W-1:CV_W]);
      pending_o        <= expected_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// File: verif/tb_battery_window_monitor_unit.sv
module tb_battery_window_monitor_unit;
  import bwm_pkg::*;

  localparam int unsigned WINDOW       = 10;
  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned IDLE_PCT     = 15;   // chance in a hundred of a gap or stall
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_WINS   = 16;   // windows per configuration phase

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [1:0]             cfg_idx_i = '0;
  logic [CV_W-1:0]        cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // When set, neither side inserts gaps or stalls
  logic steady = 1'b0;

  int mismatch_count;
  int pending_results;

  // Levels currently programmed, used to aim the samples
  int lvl_spread, lvl_ext, lvl_empty, lvl_full;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  battery_window_monitor_unit #(
    .SAMPLES(WINDOW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bwm_result_checker #(
    .SAMPLES(WINDOW)
  ) u_gauge_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  // Result side: stall at random, except during the steady stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Smallest raw ADC code that converts to at least the given centivolts
  function automatic logic [CV_W-1:0] raw_for_cv(input int cv);
    int r;
    r = (cv * 1024 + 659) / 660;
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    return r[CV_W-1:0];
  endfunction

  function automatic logic [CV_W-1:0] clamp_raw(input int r);
    if (r < 0) return '0;
    if (r > 1023) return '1;
    return r[CV_W-1:0];
  endfunction

  // Present one sample and hold it until the transfer happens
  task automatic send_sample(input logic [CV_W-1:0] batt, input logic [CV_W-1:0] ext);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({ext, batt});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid, wait for every expected result, then let the unit go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Program all four registers, one per cycle
  task automatic set_levels(input int spread, input int ext, input int empty, input int full);
    reg_idx_e        order[4] = '{REG_SPREAD_LIMIT, REG_EXT_POWER_LIMIT,
                                  REG_EMPTY_LEVEL, REG_FULL_LEVEL};
    logic [CV_W-1:0] vals[4];
    vals = '{spread[CV_W-1:0], ext[CV_W-1:0], empty[CV_W-1:0], full[CV_W-1:0]};
    lvl_spread = spread;
    lvl_ext    = ext;
    lvl_empty  = empty;
    lvl_full   = full;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One full window. Most windows cluster around a level with a spread near
  // the limit so both connected and disconnected outcomes show up; a few are
  // pure noise across the whole ADC range.
  task automatic send_window();
    int base, jitter, ext_raw;
    logic noisy;
    noisy = ($urandom_range(0, 9) < 2);
    case ($urandom_range(0, 2))
      0:       base = $urandom_range(0, 1023);
      1:       base = raw_for_cv(lvl_empty);
      default: base = raw_for_cv(lvl_full);
    endcase
    base   = base + int'($urandom_range(0, 40)) - 20;
    jitter = $urandom_range(0, lvl_spread * 1024 / 660 + 4);
    for (int k = 0; k < WINDOW; k++) begin
      // aim the external sample at its limit half the time
      if ($urandom_range(0, 1))
        ext_raw = $urandom_range(0, 1023);
      else
        ext_raw = raw_for_cv(lvl_ext) + int'($urandom_range(0, 4)) - 2;
      if (noisy)
        send_sample(CV_W'($urandom_range(0, 1023)), clamp_raw(ext_raw));
      else
        send_sample(clamp_raw(base + int'($urandom_range(0, jitter))), clamp_raw(ext_raw));
    end
  endtask

  initial begin
    int spread, ext, empty, full, tmp;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset levels. Full-scale window with external supply at zero:
    // connected, on battery, mean at the top, percentage clamped high.
    for (int k = 0; k < WINDOW; k++) send_sample('1, '0);
    // Zeros closed by one full-scale sample with full-scale supply:
    // widest spread, so disconnected and off battery.
    for (int k = 0; k < WINDOW - 1; k++) send_sample('0, '1);
    send_sample('1, '1);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin  // all limits at the bottom, widest normal span
          spread = 0; ext = 0; empty = 0; full = 659;
        end
        1: begin  // all limits at the top, reversed span
          spread = 659; ext = 659; empty = 659; full = 0;
        end
        2: begin  // equal levels
          spread = $urandom_range(0, 40); ext = $urandom_range(0, 659);
          empty = $urandom_range(0, 659); full = empty;
        end
        3: begin  // back to the reset values
          spread = 20; ext = 450; empty = 320; full = 410;
        end
        default: begin
          spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 659) : $urandom_range(0, 40);
          ext    = $urandom_range(0, 659);
          empty  = $urandom_range(0, 659);
          full   = $urandom_range(0, 659);
          case ($urandom_range(0, 3))
            0: full = empty;
            1: if (full > empty) begin
              tmp = full; full = empty; empty = tmp;
            end
            default: if (full < empty) begin
              tmp = full; full = empty; empty = tmp;
            end
          endcase
        end
      endcase
      // hold both sides busy through two whole phases
      steady <= (phase == 5 || phase == 6);
      set_levels(spread, ext, empty, full);
      repeat (PHASE_WINS) send_window();
      settle();
    end

    if (mismatch_count == 0 && pending_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("status: fail");
    $finish;
  end

endmodule
